@@ rtl/acss_pkg.sv @@
// ----------------------------------------------------------------------------
// ADC channel scan sequencer package
// Shared widths, operation and phase codes, command constants, the control
// structures of the round-robin search unit and the position wrap helper.
// ----------------------------------------------------------------------------
package acss_pkg;

    localparam int OP_W    = 2;
    localparam int CHAN_W  = 3;
    localparam int RX_W    = 32;
    localparam int CMD_W   = 32;
    localparam int PHASE_W = 3;
    localparam int VALUE_W = 18;
    localparam int MASK_W  = 8;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_ACK    = 2'd2;
    localparam logic [OP_W-1:0] OP_REINIT = 2'd3;

    localparam logic [PHASE_W-1:0] PH_WAIT_INIT  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SCANNING   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CONVERTING = 3'd3;
    localparam logic [PHASE_W-1:0] PH_COMPLETE   = 3'd4;

    localparam logic [CMD_W-1:0]  BASE_CMD         = 32'h8400_0000;
    localparam int                CMD_CHAN_SHIFT   = 27;
    localparam int                REPLY_DATA_SHIFT = 14;
    localparam int                REPLY_CHAN_SHIFT = 11;
    localparam logic [MASK_W-1:0] MASK_RESET       = 8'd3;

    typedef struct packed {
        logic                start;
        logic [MASK_W-1:0]   mask;
        logic [CHAN_W-1:0]   base;
    } search_req_t;

    typedef struct packed {
        logic                done;
        logic [CHAN_W-1:0]   chan;
    } search_rsp_t;

    // Next channel position, wrapping to zero at the channel count.
    function automatic logic [CHAN_W-1:0] wrap_inc(input logic [CHAN_W-1:0] p,
                                                   input logic [CHAN_W:0]   n);
        logic [CHAN_W:0] sum;
        sum = {1'b0, p} + {{CHAN_W{1'b0}}, 1'b1};
        return (sum >= n) ? '0 : sum[CHAN_W-1:0];
    endfunction

endpackage

@@ rtl/acss_if.sv @@
// ----------------------------------------------------------------------------
// ADC channel scan sequencer channel interfaces
// Valid/ready request channel and result channel with their payload fields.
// ----------------------------------------------------------------------------
interface acss_req_if;
    logic                          valid;
    logic                          ready;
    logic [acss_pkg::OP_W-1:0]     op;
    logic                          adc_busy;
    logic [acss_pkg::RX_W-1:0]     spi_rx;
    logic [acss_pkg::CHAN_W-1:0]   read_channel;

    modport source (output valid, op, adc_busy, spi_rx, read_channel, input ready);
    modport sink   (input valid, op, adc_busy, spi_rx, read_channel, output ready);
endinterface

interface acss_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          cnv_pulse;
    logic                          spi_cmd_valid;
    logic [acss_pkg::CMD_W-1:0]    spi_cmd;
    logic [acss_pkg::PHASE_W-1:0]  status;
    logic [acss_pkg::VALUE_W-1:0]  channel_value;

    modport source (output valid, cnv_pulse, spi_cmd_valid, spi_cmd, status,
                    channel_value, input ready);
    modport sink   (input valid, cnv_pulse, spi_cmd_valid, spi_cmd, status,
                    channel_value, output ready);
endinterface

@@ rtl/acss_rr_search.sv @@
// ----------------------------------------------------------------------------
// ADC channel scan sequencer round-robin search
// Steps one channel position per cycle from the position after the base
// until an enabled channel is found; an empty mask answers channel zero.
// ----------------------------------------------------------------------------
module acss_rr_search #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  acss_pkg::search_req_t req,
    output acss_pkg::search_rsp_t rsp
);

    localparam logic [acss_pkg::CHAN_W:0]   NCH      = (acss_pkg::CHAN_W+1)'(NUM_CHANNELS);
    localparam logic [acss_pkg::CHAN_W-1:0] CNT_LAST = acss_pkg::CHAN_W'(NUM_CHANNELS - 1);

    logic                          busy_reg;
    logic [acss_pkg::CHAN_W-1:0]   pos_reg;
    logic [acss_pkg::CHAN_W-1:0]   cnt_reg;
    logic                          empty;
    logic                          found;
    logic                          hit;
    logic [acss_pkg::CHAN_W-1:0]   pos_inc;

    assign empty   = (req.mask == '0);
    assign found   = req.mask[pos_reg];
    assign pos_inc = acss_pkg::wrap_inc(pos_reg, NCH);
    assign hit     = busy_reg && (empty || found || (cnt_reg == CNT_LAST));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
        end
        else if (hit)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            pos_reg <= acss_pkg::wrap_inc(req.base, NCH);
            cnt_reg <= '0;
        end
        else if (busy_reg && !hit)
        begin
            pos_reg <= pos_inc;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        rsp.done = hit;
        priority if (empty)
        begin
            rsp.chan = '0;
        end
        else if (found)
        begin
            rsp.chan = pos_reg;
        end
        else
        begin
            rsp.chan = pos_inc;
        end
    end

endmodule

@@ rtl/adc_channel_scan_sequencer.sv @@
// ----------------------------------------------------------------------------
// ADC channel scan sequencer
// Phase sequencer for an eight-channel SPI ADC with a result store per channel.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (op, adc_busy, spi_rx, read_channel) and
// each one produces exactly one result on the rsp channel (cnv_pulse,
// spi_cmd_valid, spi_cmd, status, channel_value). The enable mask is written
// through the APB port at any address with paddr[2] low; pready is always high.
// A request is taken in one cycle, decoded in the next, and committed in a
// finish cycle. A tick in the converting phase with busy low also runs the
// round-robin channel search, which checks one position per cycle, between
// the decode and finish cycles. The result is valid the cycle after the
// commit.
// The block takes a new request while a result still waits on rsp. When the
// receiver stalls, the next request waits in the finish cycle until the
// output register frees, and req.ready stays low meanwhile.
// Reset puts the sequencer in the wait-init phase, sets the enable mask to 3,
// and clears the scan position and every stored channel value.
// ----------------------------------------------------------------------------
module adc_channel_scan_sequencer #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    acss_req_if.sink    req,
    acss_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(NUM_CHANNELS);
    localparam logic [acss_pkg::CHAN_W:0]   NCH     = (acss_pkg::CHAN_W+1)'(NUM_CHANNELS);
    localparam logic [acss_pkg::MASK_W-1:0] CH_MASK =
        acss_pkg::MASK_W'((1 << NUM_CHANNELS) - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [acss_pkg::MASK_W-1:0]     mask_reg;
    logic [acss_pkg::PHASE_W-1:0]    phase_reg, phase_next;
    logic [acss_pkg::CHAN_W-1:0]     scan_reg, scan_next;
    logic [acss_pkg::VALUE_W-1:0]    store_reg [NUM_CHANNELS];

    logic [acss_pkg::OP_W-1:0]       op_reg;
    logic                            busy_reg;
    logic [acss_pkg::RX_W-1:0]       rx_reg;
    logic [acss_pkg::CHAN_W-1:0]     rd_reg;
    logic [acss_pkg::CHAN_W-1:0]     nxt_reg;

    logic                            ovalid_reg;
    logic                            ocnv_reg;
    logic                            ocmdv_reg;
    logic [acss_pkg::CMD_W-1:0]      ocmd_reg;
    logic [acss_pkg::PHASE_W-1:0]    ostatus_reg;
    logic [acss_pkg::VALUE_W-1:0]    ovalue_reg;

    logic [acss_pkg::MASK_W-1:0]     live_mask;
    logic                            accept;
    logic                            out_free;
    logic                            commit;
    logic                            need_search;
    logic                            cfg_write;

    logic                            clr;
    logic                            reinit;
    logic                            wr_en;
    logic [acss_pkg::CHAN_W-1:0]     wr_ch;
    logic [acss_pkg::VALUE_W-1:0]    wr_data;
    logic                            cnv;
    logic                            cmdv;
    logic [acss_pkg::CMD_W-1:0]      cmd;
    logic [acss_pkg::VALUE_W-1:0]    rd_value;
    logic [acss_pkg::VALUE_W-1:0]    value_out;

    acss_pkg::search_req_t           srch_req;
    acss_pkg::search_rsp_t           srch_rsp;

    assign live_mask   = mask_reg & CH_MASK;
    assign accept      = req.valid && req.ready;
    assign req.ready   = (state_reg == ST_IDLE);
    assign out_free    = !ovalid_reg || rsp.ready;
    assign commit      = (state_reg == ST_FINISH) && out_free;
    assign need_search = (op_reg == acss_pkg::OP_TICK) &&
                         (phase_reg == acss_pkg::PH_CONVERTING) && !busy_reg;
    assign cfg_write   = psel && penable && pwrite && !paddr[2];

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {24'd0, mask_reg};

    assign srch_req.start = (state_reg == ST_EXEC) && need_search;
    assign srch_req.mask  = live_mask;
    assign srch_req.base  = scan_reg;

    acss_rr_search #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (srch_req),
        .rsp   (srch_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = need_search ? ST_SEARCH : ST_FINISH;
            end
            ST_SEARCH:
            begin
                if (srch_rsp.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        scan_next  = scan_reg;
        clr        = 1'b0;
        reinit     = 1'b0;
        wr_en      = 1'b0;
        wr_ch      = rx_reg[acss_pkg::REPLY_CHAN_SHIFT +: acss_pkg::CHAN_W];
        wr_data    = rx_reg[acss_pkg::RX_W-1:acss_pkg::REPLY_DATA_SHIFT];
        cnv        = 1'b0;
        cmdv       = 1'b0;
        cmd        = '0;
        unique case (op_reg)
            acss_pkg::OP_REINIT:
            begin
                phase_next = acss_pkg::PH_WAIT_INIT;
                reinit     = 1'b1;
            end
            acss_pkg::OP_ACK:
            begin
                phase_next = acss_pkg::PH_IDLE;
            end
            acss_pkg::OP_START:
            begin
                if (phase_reg == acss_pkg::PH_IDLE)
                begin
                    scan_next  = '0;
                    clr        = 1'b1;
                    phase_next = acss_pkg::PH_SCANNING;
                end
            end
            acss_pkg::OP_TICK:
            begin
                unique case (phase_reg)
                    acss_pkg::PH_WAIT_INIT:
                    begin
                        cmdv       = 1'b1;
                        cmd        = acss_pkg::BASE_CMD;
                        phase_next = acss_pkg::PH_IDLE;
                    end
                    acss_pkg::PH_SCANNING:
                    begin
                        if (live_mask[scan_reg])
                        begin
                            cnv        = 1'b1;
                            phase_next = acss_pkg::PH_CONVERTING;
                        end
                        else
                        begin
                            scan_next = acss_pkg::wrap_inc(scan_reg, NCH);
                        end
                    end
                    acss_pkg::PH_CONVERTING:
                    begin
                        if (!busy_reg)
                        begin
                            cmdv = 1'b1;
                            cmd  = acss_pkg::BASE_CMD |
                                   (acss_pkg::CMD_W'(nxt_reg) << acss_pkg::CMD_CHAN_SHIFT);
                            if (rx_reg == '0)
                            begin
                                phase_next = acss_pkg::PH_SCANNING;
                            end
                            else
                            begin
                                wr_en = (rx_reg[31:24] == rx_reg[7:0]) &&
                                        ({1'b0, wr_ch} < NCH);
                                phase_next = (nxt_reg > scan_reg) ?
                                             acss_pkg::PH_SCANNING : acss_pkg::PH_COMPLETE;
                                scan_next  = nxt_reg;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign rd_value = ({1'b0, rd_reg} < NCH) ? store_reg[rd_reg[IDX_W-1:0]] : '0;

    always_comb
    begin
        priority if (clr)
        begin
            value_out = '0;
        end
        else if (wr_en && (wr_ch == rd_reg))
        begin
            value_out = wr_data;
        end
        else
        begin
            value_out = rd_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mask_reg   <= acss_pkg::MASK_RESET;
            phase_reg  <= acss_pkg::PH_WAIT_INIT;
            scan_reg   <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                mask_reg <= pwdata[acss_pkg::MASK_W-1:0];
            end
            else if (commit && reinit)
            begin
                mask_reg <= acss_pkg::MASK_RESET;
            end
            if (commit)
            begin
                phase_reg  <= phase_next;
                scan_reg   <= scan_next;
                ovalid_reg <= 1'b1;
                if (clr)
                begin
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        store_reg[i] <= '0;
                    end
                end
                else if (wr_en)
                begin
                    store_reg[wr_ch[IDX_W-1:0]] <= wr_data;
                end
            end
            else if (rsp.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.op;
            busy_reg <= req.adc_busy;
            rx_reg   <= req.spi_rx;
            rd_reg   <= req.read_channel;
        end
        if ((state_reg == ST_SEARCH) && srch_rsp.done)
        begin
            nxt_reg <= srch_rsp.chan;
        end
        if (commit)
        begin
            ocnv_reg    <= cnv;
            ocmdv_reg   <= cmdv;
            ocmd_reg    <= cmd;
            ostatus_reg <= phase_next;
            ovalue_reg  <= value_out;
        end
    end

    assign rsp.valid         = ovalid_reg;
    assign rsp.cnv_pulse     = ocnv_reg;
    assign rsp.spi_cmd_valid = ocmdv_reg;
    assign rsp.spi_cmd       = ocmd_reg;
    assign rsp.status        = ostatus_reg;
    assign rsp.channel_value = ovalue_reg;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scan sequencer regression bench
// Drives operation requests into the ADC scan sequencer through its request
// channel and checks every result against an in-bench prediction of the
// phases, scan position, enable mask and per-channel store. Runs a directed
// sequence first, then bursts of scan sequences under several mask settings
// and idling patterns, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [2:0] REG_ENABLE_MASK = 3'd0;
    localparam int         SETTLE_CYCLES   = 24;
    localparam int         RANDOM_PHASES   = 10;
    localparam int         ITEMS_PER_PHASE = 195;
    localparam int         HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic [acss_pkg::OP_W-1:0]    op;
        logic                         busy;
        logic [acss_pkg::RX_W-1:0]    rx;
        logic [acss_pkg::CHAN_W-1:0]  rd;
    } scan_req_t;

    typedef struct packed {
        logic                          cnv;
        logic                          cmd_valid;
        logic [acss_pkg::CMD_W-1:0]    cmd;
        logic [acss_pkg::PHASE_W-1:0]  status;
        logic [acss_pkg::VALUE_W-1:0]  value;
    } scan_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    acss_req_if req_ch ();
    acss_rsp_if rsp_ch ();

    adc_channel_scan_sequencer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // Predicted sequencer state.
    logic [acss_pkg::PHASE_W-1:0] sq_phase;
    logic [acss_pkg::CHAN_W-1:0]  sq_pos;
    logic [acss_pkg::VALUE_W-1:0] sq_store [8];
    logic [acss_pkg::MASK_W-1:0]  sq_mask;

    scan_req_t req_backlog [$];
    scan_rsp_t seq_out_q [$];

    int src_gap_pct;
    int snk_stall_pct;
    bit hold_off_armed;
    bit hold_off_used;
    int hold_off_left;

    int n_queued;
    int n_accepted;
    int n_checked;
    int n_errors;
    int n_settings;
    int n_cnv;
    int n_cmds;
    int n_stores;
    int n_completions;

    always #2 clk = ~clk;

    function automatic logic [acss_pkg::CHAN_W-1:0] next_enabled_channel();
        logic [acss_pkg::CHAN_W-1:0] p;
        if (sq_mask == '0)
            return '0;
        p = sq_pos + 1'b1;
        for (int n = 0; n < 8; n++)
        begin
            if (sq_mask[p])
                return p;
            p = p + 1'b1;
        end
        return p;
    endfunction

    function automatic scan_rsp_t advance_sequencer(input scan_req_t r);
        scan_rsp_t                   o;
        logic [acss_pkg::CHAN_W-1:0] nxt;
        logic [acss_pkg::CHAN_W-1:0] ch;
        o = '0;
        case (r.op)
            acss_pkg::OP_REINIT:
            begin
                sq_phase = acss_pkg::PH_WAIT_INIT;
                sq_mask  = acss_pkg::MASK_RESET;
            end
            acss_pkg::OP_ACK:
                sq_phase = acss_pkg::PH_IDLE;
            acss_pkg::OP_START:
            begin
                if (sq_phase == acss_pkg::PH_IDLE)
                begin
                    sq_pos = '0;
                    foreach (sq_store[i])
                        sq_store[i] = '0;
                    sq_phase = acss_pkg::PH_SCANNING;
                end
            end
            default:
            begin
                if (sq_phase == acss_pkg::PH_WAIT_INIT)
                begin
                    o.cmd_valid = 1'b1;
                    o.cmd       = acss_pkg::BASE_CMD;
                    sq_phase    = acss_pkg::PH_IDLE;
                end
                else if (sq_phase == acss_pkg::PH_SCANNING)
                begin
                    if (sq_mask[sq_pos])
                    begin
                        o.cnv    = 1'b1;
                        sq_phase = acss_pkg::PH_CONVERTING;
                    end
                    else
                    begin
                        sq_pos = sq_pos + 1'b1;
                    end
                end
                else if (sq_phase == acss_pkg::PH_CONVERTING && !r.busy)
                begin
                    nxt         = next_enabled_channel();
                    o.cmd_valid = 1'b1;
                    o.cmd       = acss_pkg::BASE_CMD |
                                  (32'(nxt) << acss_pkg::CMD_CHAN_SHIFT);
                    if (r.rx == '0)
                    begin
                        sq_phase = acss_pkg::PH_SCANNING;
                    end
                    else
                    begin
                        if (r.rx[31:24] == r.rx[7:0])
                        begin
                            ch = r.rx[acss_pkg::REPLY_CHAN_SHIFT +: acss_pkg::CHAN_W];
                            sq_store[ch] = r.rx[acss_pkg::REPLY_DATA_SHIFT +: acss_pkg::VALUE_W];
                            n_stores++;
                        end
                        sq_phase = (nxt > sq_pos) ? acss_pkg::PH_SCANNING
                                                  : acss_pkg::PH_COMPLETE;
                        if (sq_phase == acss_pkg::PH_COMPLETE)
                            n_completions++;
                        sq_pos = nxt;
                    end
                end
            end
        endcase
        o.status = sq_phase;
        o.value  = sq_store[r.rd];
        n_cnv  += o.cnv;
        n_cmds += o.cmd_valid;
        return o;
    endfunction

    // Reply whose top byte matches its bottom byte.
    function automatic logic [acss_pkg::RX_W-1:0] good_reply(
        input logic [acss_pkg::VALUE_W-1:0] data,
        input logic [acss_pkg::CHAN_W-1:0]  ch,
        input logic [2:0]                   fill
    );
        return {data, ch, fill, data[acss_pkg::VALUE_W-1 -: 8]};
    endfunction

    function automatic scan_req_t random_tick();
        scan_req_t r;
        int        k;
        r.op   = acss_pkg::OP_TICK;
        r.busy = ($urandom_range(0, 99) < 25);
        r.rd   = acss_pkg::CHAN_W'($urandom_range(0, 7));
        k      = $urandom_range(0, 99);
        r.rx   = good_reply(acss_pkg::VALUE_W'($urandom), acss_pkg::CHAN_W'($urandom),
                            3'($urandom));
        if (k >= 95)
            r.rx = $urandom;
        else if (k >= 88)
            r.rx[7:0] = r.rx[31:24] ^ 8'($urandom_range(1, 255));
        else if (k >= 80)
            r.rx = '0;
        return r;
    endfunction

    task automatic push_item(input logic [acss_pkg::OP_W-1:0] op, input logic busy,
                             input logic [acss_pkg::RX_W-1:0] rx,
                             input logic [acss_pkg::CHAN_W-1:0] rd);
        scan_req_t r;
        r.op   = op;
        r.busy = busy;
        r.rx   = rx;
        r.rd   = rd;
        req_backlog.push_back(r);
        n_queued++;
    endtask

    task automatic queue_random_traffic(input int count);
        int made;
        int k;
        int ticks;
        scan_req_t r;
        made = 0;
        while (made < count)
        begin
            k = $urandom_range(0, 99);
            if (k < 82)
            begin
                push_item(acss_pkg::OP_ACK, 1'($urandom), $urandom,
                          acss_pkg::CHAN_W'($urandom));
                push_item(acss_pkg::OP_START, 1'($urandom), $urandom,
                          acss_pkg::CHAN_W'($urandom));
                ticks = $urandom_range(4, 40);
                repeat (ticks)
                begin
                    req_backlog.push_back(random_tick());
                    n_queued++;
                end
                made += ticks + 2;
            end
            else if (k < 88)
            begin
                push_item(acss_pkg::OP_REINIT, 1'($urandom), $urandom,
                          acss_pkg::CHAN_W'($urandom));
                push_item(acss_pkg::OP_TICK, 1'($urandom), $urandom,
                          acss_pkg::CHAN_W'($urandom));
                made += 2;
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    r.op   = acss_pkg::OP_W'($urandom_range(0, 3));
                    r.busy = 1'($urandom);
                    r.rx   = $urandom;
                    r.rd   = acss_pkg::CHAN_W'($urandom);
                    req_backlog.push_back(r);
                    n_queued++;
                    made++;
                end
            end
        end
    endtask

    task automatic wait_quiet();
        while (n_accepted != n_queued || seq_out_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_enable_mask(input logic [acss_pkg::MASK_W-1:0] mask);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ENABLE_MASK;
        pwdata  <= {24'($urandom), mask};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sq_mask = mask;
        n_settings++;
    endtask

    // Request driver.
    always @(posedge clk)
    begin
        scan_req_t taken;
        scan_req_t nxt;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                taken.op   = req_ch.op;
                taken.busy = req_ch.adc_busy;
                taken.rx   = req_ch.spi_rx;
                taken.rd   = req_ch.read_channel;
                seq_out_q.push_back(advance_sequencer(taken));
                n_accepted++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= src_gap_pct)
                begin
                    nxt = req_backlog.pop_front();
                    req_ch.op           <= nxt.op;
                    req_ch.adc_busy     <= nxt.busy;
                    req_ch.spi_rx       <= nxt.rx;
                    req_ch.read_channel <= nxt.rd;
                    req_ch.valid        <= 1'b1;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted in cycles.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_off_left <= 0;
        end
        else if (hold_off_armed && !hold_off_used)
        begin
            hold_off_used <= 1'b1;
            hold_off_left <= HOLD_OFF_CYCLES;
        end
        else if (hold_off_left > 0)
        begin
            hold_off_left <= hold_off_left - 1;
        end
    end

    // Result monitor and receiver.
    always @(posedge clk)
    begin
        scan_rsp_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_checked++;
                if (seq_out_q.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    n_errors++;
                end
                else
                begin
                    want = seq_out_q.pop_front();
                    if (rsp_ch.cnv_pulse !== want.cnv)
                    begin
                        $error("cnv_pulse: expected %0d, got %0d", want.cnv, rsp_ch.cnv_pulse);
                        n_errors++;
                    end
                    if (rsp_ch.spi_cmd_valid !== want.cmd_valid)
                    begin
                        $error("spi_cmd_valid: expected %0d, got %0d",
                               want.cmd_valid, rsp_ch.spi_cmd_valid);
                        n_errors++;
                    end
                    if (rsp_ch.spi_cmd !== want.cmd)
                    begin
                        $error("spi_cmd: expected %h, got %h", want.cmd, rsp_ch.spi_cmd);
                        n_errors++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        n_errors++;
                    end
                    if (rsp_ch.channel_value !== want.value)
                    begin
                        $error("channel_value: expected %h, got %h",
                               want.value, rsp_ch.channel_value);
                        n_errors++;
                    end
                end
            end
            if (hold_off_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [acss_pkg::MASK_W-1:0] mask;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.op           = acss_pkg::OP_TICK;
        req_ch.adc_busy     = 1'b0;
        req_ch.spi_rx       = '0;
        req_ch.read_channel = '0;
        rsp_ch.ready        = 1'b0;
        src_gap_pct         = 0;
        snk_stall_pct       = 0;
        hold_off_armed      = 1'b0;
        sq_phase            = acss_pkg::PH_WAIT_INIT;
        sq_pos              = '0;
        sq_mask             = acss_pkg::MASK_RESET;
        foreach (sq_store[i])
            sq_store[i] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed sequence on the reset mask.
        push_item(acss_pkg::OP_START, 1'b0, 32'h0, 3'd0);
        push_item(acss_pkg::OP_TICK, 1'b1, 32'hFFFF_FFFF, 3'd0);
        push_item(acss_pkg::OP_TICK, 1'b0, 32'h0, 3'd0);
        push_item(acss_pkg::OP_ACK, 1'b0, 32'h0, 3'd0);
        push_item(acss_pkg::OP_START, 1'b0, 32'h0, 3'd0);
        push_item(acss_pkg::OP_START, 1'b0, 32'h0, 3'd0);
        push_item(acss_pkg::OP_TICK, 1'b0, 32'h0, 3'd0);
        push_item(acss_pkg::OP_TICK, 1'b1, good_reply(18'h2AAAA, 3'd5, 3'd0), 3'd5);
        push_item(acss_pkg::OP_TICK, 1'b0, 32'h0, 3'd0);
        push_item(acss_pkg::OP_TICK, 1'b0, 32'h0, 3'd0);
        push_item(acss_pkg::OP_TICK, 1'b0, 32'hFFFF_FFFF, 3'd7);
        push_item(acss_pkg::OP_TICK, 1'b0, 32'h0, 3'd7);
        push_item(acss_pkg::OP_TICK, 1'b0, 32'h0000_00FF, 3'd7);
        push_item(acss_pkg::OP_TICK, 1'b0, 32'h0, 3'd7);
        push_item(acss_pkg::OP_START, 1'b0, 32'h0, 3'd7);
        push_item(acss_pkg::OP_REINIT, 1'b1, 32'h0, 3'd7);
        push_item(acss_pkg::OP_TICK, 1'b0, 32'h0, 3'd7);
        push_item(acss_pkg::OP_START, 1'b0, 32'h0, 3'd7);
        push_item(acss_pkg::OP_TICK, 1'b0, 32'h0, 3'd0);
        push_item(acss_pkg::OP_TICK, 1'b0, good_reply(18'h00001, 3'd0, 3'd7), 3'd0);
        push_item(acss_pkg::OP_TICK, 1'b0, 32'h0, 3'd0);
        wait_quiet();

        // Converting with the mask emptied underneath it.
        write_enable_mask(8'h00);
        push_item(acss_pkg::OP_TICK, 1'b0, good_reply(18'h15555, 3'd3, 3'd2), 3'd3);
        push_item(acss_pkg::OP_ACK, 1'b0, 32'h0, 3'd3);
        push_item(acss_pkg::OP_START, 1'b0, 32'h0, 3'd3);
        push_item(acss_pkg::OP_TICK, 1'b0, 32'h0, 3'd3);
        wait_quiet();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: mask = 8'hFF;
                1: mask = 8'h00;
                2: mask = 8'h80;
                3: mask = 8'h81;
                4: mask = 8'h01;
                default: mask = acss_pkg::MASK_W'($urandom);
            endcase
            write_enable_mask(mask);
            case (ph % 4)
                0:
                begin
                    src_gap_pct   = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_gap_pct   = 52;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_gap_pct   = 0;
                    snk_stall_pct = 52;
                end
                default:
                begin
                    src_gap_pct   = 27;
                    snk_stall_pct = 27;
                end
            endcase
            if (ph == 4)
            begin
                src_gap_pct    = 0;
                snk_stall_pct  = 0;
                hold_off_armed = 1'b1;
            end
            queue_random_traffic(ITEMS_PER_PHASE);
            wait_quiet();
        end

        $display("Checked %0d results from %0d requests over %0d mask settings.",
                 n_checked, n_accepted, n_settings);
        $display("Predicted %0d convert strobes, %0d SPI commands, %0d stored replies, %0d %s",
                 n_cnv, n_cmds, n_stores, n_completions, "completions.");
        if (n_errors == 0 && seq_out_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
